[src/pprd_pkg.sv]
package pprd_pkg;

   localparam int LEN_W = 24;
   localparam int DIM_W = 16;

   localparam logic [3:0] SPLIT_MAX       = 4'd13;
   localparam logic [3:0] CODE_REPEAT     = 4'd14;
   localparam logic [3:0] CODE_REPEAT_ONE = 4'd15;
   localparam logic [3:0] ZERO_COUNT_MAX  = 4'd15;

   localparam logic [LEN_W-1:0] RUN_LEN_MAX = {LEN_W{1'b1}};
   localparam logic [DIM_W-1:0] REPEAT_MAX  = {DIM_W{1'b1}};

   localparam logic [1:0] REG_RUN_SPLIT    = 2'd0;
   localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd1;
   localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd2;
   localparam logic [1:0] REG_STARTS_BLACK = 2'd3;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_RUN    = 2'd1,
      CMD_REPEAT = 2'd2,
      CMD_END    = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [LEN_W-1:0] value;
      logic             ovf;
   } cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } back_status_type;

   typedef struct packed {
      logic             run_black;
      logic [LEN_W-1:0] run_length;
      logic [DIM_W-1:0] start_row;
      logic [DIM_W-1:0] start_col;
      logic [DIM_W-1:0] repeat_rows;
      logic             glyph_done;
      logic             number_overflow;
      logic             last_of_item;
   } result_type;

endpackage

[src/pprd_req_if.sv]
interface pprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       glyph_start;

   modport source (output valid, output byte_in, output glyph_start, input ready);
   modport sink (input valid, input byte_in, input glyph_start, output ready);
endinterface

[src/pprd_rsp_if.sv]
interface pprd_rsp_if;
   logic        valid;
   logic        ready;
   logic        run_black;
   logic [23:0] run_length;
   logic [15:0] start_row;
   logic [15:0] start_col;
   logic [15:0] repeat_rows;
   logic        glyph_done;
   logic        number_overflow;
   logic        last_of_item;

   modport source (output valid, output run_black, output run_length, output start_row,
                   output start_col, output repeat_rows, output glyph_done,
                   output number_overflow, output last_of_item, input ready);
   modport sink (input valid, input run_black, input run_length, input start_row,
                 input start_col, input repeat_rows, input glyph_done,
                 input number_overflow, input last_of_item, output ready);
endinterface

[src/pprd_cmd_queue.sv]
module pprd_cmd_queue import pprd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop && !empty) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/pprd_front.sv]
module pprd_front import pprd_pkg::*; #(
   parameter int MAX_NUMBER_NYBBLES = 8
) (
   input  logic            clock,
   input  logic            reset,
   pprd_req_if.sink        req_chan,
   input  logic [3:0]      run_split,
   input  back_status_type back_status,
   input  logic            q_full,
   input  logic            q_empty,
   output logic            q_push,
   output cmd_type         q_cmd
);

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_START = 4'b0010,
      F_NYB   = 4'b0100,
      F_END   = 4'b1000
   } front_state_type;

   typedef enum logic [3:0] {
      D_IDLE   = 4'b0001,
      D_ZEROS  = 4'b0010,
      D_DIGITS = 4'b0100,
      D_LONG   = 4'b1000
   } dec_phase_type;

   front_state_type state_ff, state_in;
   dec_phase_type   phase_ff, phase_in;
   logic [7:0]      byte_ff, byte_in_d;
   logic            k_ff, k_in;
   logic [3:0]      lc_ff, lc_in;
   logic [31:0]     acc_ff, acc_in;
   logic [3:0]      fc_ff, fc_in;
   logic            in_rep_ff, in_rep_in;
   logic            ovf_ff, ovf_in;

   dec_phase_type   dec_phase;
   logic [3:0]      dec_lc, dec_fc;
   logic [31:0]     dec_acc;
   logic            dec_in_rep, dec_ovf, dec_fin;
   logic [33:0]     dec_val;
   logic [3:0]      d, n;
   logic [35:0]     acc_sh;
   logic [7:0]      d15;
   logic [9:0]      long_hi;
   logic            quiet;

   assign d       = (run_split > SPLIT_MAX) ? SPLIT_MAX : run_split;
   assign n       = k_ff ? byte_ff[3:0] : byte_ff[7:4];
   assign acc_sh  = {acc_ff, n};
   assign d15     = {d, 4'b0000} - {4'b0000, d};
   assign long_hi = {2'b00, fc_ff - d - 4'd1, 4'b0000};
   assign quiet   = q_empty && back_status.idle;

   assign req_chan.ready = (state_ff == F_IDLE);

   // one nybble through the packed number decoder
   always_comb begin
      dec_phase  = phase_ff;
      dec_lc     = lc_ff;
      dec_fc     = fc_ff;
      dec_acc    = acc_ff;
      dec_in_rep = in_rep_ff;
      dec_ovf    = ovf_ff;
      dec_fin    = 1'b0;
      dec_val    = 34'd0;
      unique case (phase_ff)
         D_ZEROS: begin
            if (n == 4'd0) begin
               if (lc_ff < ZERO_COUNT_MAX) begin
                  dec_lc = lc_ff + 4'd1;
               end
            end else begin
               if ({1'b0, lc_ff} + 5'd1 > 5'(MAX_NUMBER_NYBBLES)) begin
                  dec_ovf = 1'b1;
               end
               dec_acc   = {28'd0, n};
               dec_phase = D_DIGITS;
            end
         end
         D_DIGITS: begin
            if (acc_sh[35:32] != 4'd0) begin
               dec_acc = 32'hFFFF_FFFF;
               dec_ovf = 1'b1;
            end else begin
               dec_acc = acc_sh[31:0];
            end
            dec_lc = lc_ff - 4'd1;
            if (dec_lc == 4'd0) begin
               dec_fin   = 1'b1;
               dec_phase = D_IDLE;
               dec_val   = {2'b00, dec_acc} + 34'd193 - {26'd0, d15};
            end
         end
         D_LONG: begin
            dec_fin   = 1'b1;
            dec_phase = D_IDLE;
            dec_val   = {24'd0, long_hi} + {30'd0, n} + {30'd0, d} + 34'd1;
         end
         D_IDLE: begin
            if (n == 4'd0) begin
               dec_lc    = 4'd1;
               dec_phase = D_ZEROS;
            end else if (n <= d) begin
               dec_fin = 1'b1;
               dec_val = {30'd0, n};
            end else if (n < CODE_REPEAT) begin
               dec_fc    = n;
               dec_phase = D_LONG;
            end else if (n == CODE_REPEAT) begin
               dec_in_rep = 1'b1;
            end else begin
               dec_in_rep = 1'b1;
               dec_fin    = 1'b1;
               dec_val    = 34'd1;
            end
         end
         default: begin
            dec_phase = D_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      byte_in_d = byte_ff;
      k_in      = k_ff;
      lc_in     = lc_ff;
      acc_in    = acc_ff;
      fc_in     = fc_ff;
      in_rep_in = in_rep_ff;
      ovf_in    = ovf_ff;
      q_push    = 1'b0;
      q_cmd     = '{kind: CMD_END, value: '0, ovf: 1'b0};
      unique case (state_ff)
         F_IDLE: begin
            if (req_chan.valid) begin
               byte_in_d = req_chan.byte_in;
               k_in      = 1'b0;
               state_in  = req_chan.glyph_start ? F_START : F_NYB;
            end
         end
         F_START: begin
            if (!q_full) begin
               q_push    = 1'b1;
               q_cmd     = '{kind: CMD_START, value: '0, ovf: 1'b0};
               phase_in  = D_IDLE;
               lc_in     = 4'd0;
               acc_in    = 32'd0;
               fc_in     = 4'd0;
               in_rep_in = 1'b0;
               ovf_in    = 1'b0;
               state_in  = F_NYB;
            end
         end
         F_NYB: begin
            if (quiet) begin
               if (back_status.done) begin
                  state_in = F_END;
               end else begin
                  phase_in  = dec_phase;
                  lc_in     = dec_lc;
                  acc_in    = dec_acc;
                  fc_in     = dec_fc;
                  in_rep_in = dec_in_rep;
                  ovf_in    = dec_ovf;
                  if (dec_fin && dec_in_rep) begin
                     in_rep_in = 1'b0;
                     q_push    = 1'b1;
                     if (dec_val > {18'd0, REPEAT_MAX}) begin
                        ovf_in = 1'b1;
                        q_cmd  = '{kind: CMD_REPEAT, value: {8'd0, REPEAT_MAX}, ovf: 1'b0};
                     end else begin
                        q_cmd  = '{kind: CMD_REPEAT, value: dec_val[LEN_W-1:0], ovf: 1'b0};
                     end
                  end else if (dec_fin) begin
                     q_push = 1'b1;
                     ovf_in = 1'b0;
                     if (dec_val > {10'd0, RUN_LEN_MAX}) begin
                        q_cmd = '{kind: CMD_RUN, value: RUN_LEN_MAX, ovf: 1'b1};
                     end else begin
                        q_cmd = '{kind: CMD_RUN, value: dec_val[LEN_W-1:0], ovf: dec_ovf};
                     end
                  end
                  k_in = 1'b1;
                  if (k_ff) begin
                     state_in = F_END;
                  end
               end
            end
         end
         F_END: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_cmd    = '{kind: CMD_END, value: '0, ovf: 1'b0};
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         phase_ff  <= D_IDLE;
         k_ff      <= 1'b0;
         lc_ff     <= 4'd0;
         acc_ff    <= 32'd0;
         fc_ff     <= 4'd0;
         in_rep_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         k_ff      <= k_in;
         lc_ff     <= lc_in;
         acc_ff    <= acc_in;
         fc_ff     <= fc_in;
         in_rep_ff <= in_rep_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_d;
   end

   // decoding waits for the back end, so a push never meets a full queue
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full && state_ff == F_NYB))
      else $error("front pushed into a full command queue");

endmodule

[src/pprd_back.sv]
module pprd_back import pprd_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] glyph_width,
   input  logic [DIM_W-1:0] glyph_height,
   input  logic             starts_black,
   input  logic             q_valid,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   output back_status_type  back_status,
   pprd_rsp_if.source       rsp_chan
);

   localparam int PB = POSITION_BITS;
   localparam int WW = (PB > DIM_W) ? PB : DIM_W;
   localparam int SW = LEN_W + 2;
   localparam int CW = LEN_W + 1;
   localparam logic [WW-1:0] POS_MAX_W = WW'((64'd1 << PB) - 64'd1);

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_DIV   = 5'b00010,
      B_FIN   = 5'b00100,
      B_PLACE = 5'b01000,
      B_END   = 5'b10000
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [PB-1:0]    row_ff, row_in;
   logic [PB-1:0]    col_ff, col_in;
   logic [DIM_W-1:0] pend_ff, pend_in;
   logic             black_ff, black_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             wrap_ff, wrap_in;
   logic [LEN_W-1:0] div_ff, div_in;
   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   result_type       res_ff, res_in;
   result_type       hold_ff, hold_in;
   logic             hold_v_ff, hold_v_in;
   result_type       out_ff, out_in;
   logic             out_v_ff, out_v_in;

   logic [DIM_W-1:0] w;
   logic [WW-1:0]    lim, row_w, col_w, w_w;
   logic [DIM_W-1:0] left;
   logic [DIM_W:0]   rem_sh;
   logic             ge;
   logic [SW-1:0]    row_sum;
   logic [CW-1:0]    col_sum;
   logic [WW-1:0]    row_new;
   logic [WW-1:0]    col_new;
   logic             out_free;

   assign w      = (glyph_width == '0) ? DIM_W'(1) : glyph_width;
   assign w_w    = WW'(w);
   assign row_w  = WW'(row_ff);
   assign col_w  = WW'(col_ff);
   assign lim    = (WW'(glyph_height) < POS_MAX_W) ? WW'(glyph_height) : POS_MAX_W;
   assign left   = (col_w < w_w) ? DIM_W'(w_w - col_w) : '0;
   assign rem_sh = {rem_ff, div_ff[LEN_W-1]};
   assign ge     = (rem_sh >= {1'b0, w});

   assign row_sum = SW'(row_ff) + SW'(1) + SW'(pend_ff) + SW'(div_ff);
   assign col_sum = CW'(col_ff) + CW'(len_ff);

   always_comb begin
      if (wrap_ff) begin
         row_new = (row_sum > SW'(lim)) ? lim : WW'(row_sum);
         col_new = (WW'(rem_ff) > POS_MAX_W) ? POS_MAX_W : WW'(rem_ff);
      end else begin
         row_new = row_w;
         col_new = (col_sum > CW'(POS_MAX_W)) ? POS_MAX_W : WW'(col_sum);
      end
   end

   assign out_free         = !out_v_ff || rsp_chan.ready;
   assign q_pop            = (state_ff == B_IDLE) && q_valid;
   assign back_status.idle = (state_ff == B_IDLE);
   assign back_status.done = (row_w >= lim);

   assign rsp_chan.valid           = out_v_ff;
   assign rsp_chan.run_black       = out_ff.run_black;
   assign rsp_chan.run_length      = out_ff.run_length;
   assign rsp_chan.start_row       = out_ff.start_row;
   assign rsp_chan.start_col       = out_ff.start_col;
   assign rsp_chan.repeat_rows     = out_ff.repeat_rows;
   assign rsp_chan.glyph_done      = out_ff.glyph_done;
   assign rsp_chan.number_overflow = out_ff.number_overflow;
   assign rsp_chan.last_of_item    = out_ff.last_of_item;

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      pend_in   = pend_ff;
      black_in  = black_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      wrap_in   = wrap_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && !rsp_chan.ready;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  CMD_START: begin
                     row_in   = '0;
                     col_in   = '0;
                     pend_in  = '0;
                     black_in = starts_black;
                  end
                  CMD_REPEAT: begin
                     pend_in = q_cmd.value[DIM_W-1:0];
                  end
                  CMD_RUN: begin
                     len_in  = q_cmd.value;
                     ovf_in  = q_cmd.ovf;
                     wrap_in = (q_cmd.value >= LEN_W'(left));
                     div_in  = q_cmd.value - LEN_W'(left);
                     rem_in  = '0;
                     cnt_in  = 5'(LEN_W - 1);
                     if (q_cmd.value >= LEN_W'(left)) begin
                        state_in = B_DIV;
                     end else begin
                        div_in   = '0;
                        state_in = B_FIN;
                     end
                  end
                  CMD_END: begin
                     state_in = B_END;
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         B_DIV: begin
            rem_in = ge ? DIM_W'(rem_sh - {1'b0, w}) : rem_sh[DIM_W-1:0];
            div_in = {div_ff[LEN_W-2:0], ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            res_in.run_black       = black_ff;
            res_in.run_length      = len_ff;
            res_in.start_row       = row_w[DIM_W-1:0];
            res_in.start_col       = col_w[DIM_W-1:0];
            res_in.repeat_rows     = wrap_ff ? pend_ff : '0;
            res_in.glyph_done      = (row_new >= lim);
            res_in.number_overflow = ovf_ff;
            res_in.last_of_item    = 1'b0;
            row_in   = PB'(row_new);
            col_in   = PB'(col_new);
            black_in = ~black_ff;
            if (wrap_ff) begin
               pend_in = '0;
            end
            state_in = B_PLACE;
         end
         B_PLACE: begin
            if (!hold_v_ff) begin
               hold_in   = res_ff;
               hold_v_in = 1'b1;
               state_in  = B_IDLE;
            end else if (out_free) begin
               out_in    = hold_ff;
               out_v_in  = 1'b1;
               hold_in   = res_ff;
               state_in  = B_IDLE;
            end
         end
         B_END: begin
            if (!hold_v_ff) begin
               state_in = B_IDLE;
            end else if (out_free) begin
               out_in              = hold_ff;
               out_in.last_of_item = 1'b1;
               out_v_in            = 1'b1;
               hold_v_in           = 1'b0;
               state_in            = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         row_ff    <= '0;
         col_ff    <= '0;
         pend_ff   <= '0;
         black_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         pend_ff   <= pend_in;
         black_ff  <= black_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      ovf_ff  <= ovf_in;
      wrap_ff <= wrap_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV && cnt_ff == 5'd0) |=> (state_ff == B_FIN))
      else $error("divider did not hand over to the finish step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_END && hold_v_ff && out_free) |=> (!hold_v_ff && out_v_ff && out_ff.last_of_item))
      else $error("end of byte did not flush the held run");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PLACE) |=> (hold_v_ff || state_ff == B_PLACE))
      else $error("placed run lost from the hold register");

endmodule

[src/pk_packed_run_decoder.sv]
// PK packed run decoder
// req_chan: one raster stream byte per transfer, high nybble first; glyph_start
// on the first byte of a glyph restarts nybble decoding, position and colour.
// rsp_chan: one transfer per decoded run with colour, length, start row and
// column, row repeat count, glyph done and overflow flags; last_of_item marks
// the final run of a byte (a byte gives zero, one or two runs).
// csr_*: register writes (run split, glyph width, glyph height, starts black);
// the user must make them only while the block is idle; the block does not enforce this.
// A front decoder turns nybbles into run and repeat commands and feeds a
// two-entry queue to a back end that tracks position and emits runs.
// Each nybble waits for the back end to drain so the glyph done check is current.
// A nybble that ends a run passes the back end's finish and place steps; a run
// that completes a row first goes through the 24-step bit-serial divider.
// Reset clears the control state and sets the registers to run split 0,
// width 1, height 1, starts black 0. A stalled receiver holds the output
// register; the back end keeps one further run in a hold register, then stops.
module pk_packed_run_decoder import pprd_pkg::*; #(
   parameter int MAX_NUMBER_NYBBLES = 8,
   parameter int POSITION_BITS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   pprd_req_if.sink    req_chan,
   pprd_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [3:0]       run_split_ff;
   logic [DIM_W-1:0] glyph_width_ff;
   logic [DIM_W-1:0] glyph_height_ff;
   logic             starts_black_ff;

   back_status_type  back_status;
   logic             q_push, q_pop, q_full, q_empty;
   cmd_type          push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_split_ff    <= 4'd0;
         glyph_width_ff  <= DIM_W'(1);
         glyph_height_ff <= DIM_W'(1);
         starts_black_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RUN_SPLIT:    run_split_ff    <= csr_wdata[3:0];
            REG_GLYPH_WIDTH:  glyph_width_ff  <= csr_wdata;
            REG_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata;
            REG_STARTS_BLACK: starts_black_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   pprd_front #(
      .MAX_NUMBER_NYBBLES(MAX_NUMBER_NYBBLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .run_split  (run_split_ff),
      .back_status(back_status),
      .q_full     (q_full),
      .q_empty    (q_empty),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   pprd_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .pop     (q_pop),
      .pop_cmd (pop_cmd),
      .full    (q_full),
      .empty   (q_empty)
   );

   pprd_back #(
      .POSITION_BITS(POSITION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .glyph_width (glyph_width_ff),
      .glyph_height(glyph_height_ff),
      .starts_black(starts_black_ff),
      .q_valid     (!q_empty),
      .q_cmd       (pop_cmd),
      .q_pop       (q_pop),
      .back_status (back_status),
      .rsp_chan    (rsp_chan)
   );

endmodule
